@@ src/itas_pkg.sv @@
// itas_pkg: character codes, operator codes and result records shared by the
// infix-to-three-address-steps block; no dependencies
package itas_pkg;

  localparam logic [7:0] CHAR_A     = 8'd97;
  localparam logic [7:0] CHAR_M     = 8'd109;
  localparam logic [7:0] TEMP_BASE  = 8'd122;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_TIMES = 8'h2A;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam int OPERATOR_DEPTH = 2;

  // one emitted step
  typedef struct packed {
    logic [1:0] op_kind;
    logic [7:0] right_operand;
    logic [7:0] left_operand;
    logic [7:0] temp_name;
    logic       last_of_run;
    logic       expression_done;
    logic       malformed;
  } res_t;

  // steps produced by one character
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } emit_t;

endpackage

@@ src/itas_in_if.sv @@
// itas_in_if: character channel (valid/ready) of the infix-to-steps block
// depends on nothing
interface itas_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expression;

  modport source(output valid, char_code, end_of_expression, input ready);
  modport sink(input valid, char_code, end_of_expression, output ready);
endinterface

@@ src/itas_out_if.sv @@
// itas_out_if: step channel (valid/ready) of the infix-to-steps block
// depends on nothing
interface itas_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] op_kind;
  logic [7:0] right_operand;
  logic [7:0] left_operand;
  logic [7:0] temp_name;
  logic       last_of_run;
  logic       expression_done;
  logic       malformed;

  modport source(output valid, op_kind, right_operand, left_operand, temp_name,
                 last_of_run, expression_done, malformed, input ready);
  modport sink(input valid, op_kind, right_operand, left_operand, temp_name,
               last_of_run, expression_done, malformed, output ready);
endinterface

@@ src/itas_reduce.sv @@
// itas_reduce: one reduction (pop operator, pop two operands, push temporary)
// as pure combinational logic; uses itas_pkg
module itas_reduce #(
  parameter int DEPTH = 4
) (
  input  logic                                   en_i,
  input  logic [DEPTH-1:0][7:0]                  stk_i,
  input  logic [$clog2(DEPTH+1)-1:0]             cnt_i,
  input  logic [itas_pkg::OPERATOR_DEPTH-1:0][1:0] ops_i,
  input  logic [1:0]                             opc_i,
  input  logic [7:0]                             step_i,
  output logic [DEPTH-1:0][7:0]                  stk_o,
  output logic [$clog2(DEPTH+1)-1:0]             cnt_o,
  output logic [1:0]                             opc_o,
  output logic [7:0]                             step_o,
  output logic [1:0]                             op_kind_o,
  output logic [7:0]                             right_o,
  output logic [7:0]                             left_o,
  output logic [7:0]                             temp_o,
  output logic                                   malformed_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [1:0]    opc_dec;
  logic [CW-1:0] cnt_mid;
  logic [CW-1:0] cnt_low;
  logic          empty_r_pop;
  logic          empty_l_pop;

  always_comb begin
    opc_dec     = opc_i - 2'd1;
    op_kind_o   = ops_i[opc_dec[0]];
    temp_o      = itas_pkg::TEMP_BASE - step_i;

    // right-hand operand
    empty_r_pop = (cnt_i == '0);
    cnt_mid     = empty_r_pop ? cnt_i : cnt_i - CW'(1);
    right_o     = empty_r_pop ? 8'd0 : stk_i[cnt_mid[IW-1:0]];

    // left-hand operand
    empty_l_pop = (cnt_mid == '0);
    cnt_low     = empty_l_pop ? cnt_mid : cnt_mid - CW'(1);
    left_o      = empty_l_pop ? 8'd0 : stk_i[cnt_low[IW-1:0]];

    malformed_o = empty_r_pop | empty_l_pop;

    stk_o  = stk_i;
    cnt_o  = cnt_i;
    opc_o  = opc_i;
    step_o = step_i;
    if (en_i) begin
      // after two pops there is always room for the temporary
      stk_o[cnt_low[IW-1:0]] = temp_o;
      cnt_o  = cnt_low + CW'(1);
      opc_o  = opc_dec;
      step_o = step_i + 8'd1;
    end
  end

endmodule

@@ src/itas_core.sv @@
// itas_core: operand/operator stacks, step counter and the two chained
// reductions of one character; uses itas_pkg and itas_reduce
module itas_core #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv_i,
  input  logic [7:0]          char_i,
  input  logic                end_i,
  output itas_pkg::emit_t     emit_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int OD = itas_pkg::OPERATOR_DEPTH;

  logic [DEPTH-1:0][7:0] stk_r,  stk_nxt;
  logic [CW-1:0]         cnt_r,  cnt_nxt;
  logic [OD-1:0][1:0]    ops_r,  ops_nxt;
  logic [1:0]            opc_r,  opc_nxt;
  logic [7:0]            step_r, step_nxt;

  logic       is_operand;
  logic       is_opr;
  logic [1:0] kind;
  logic [1:0] opc_m1;
  logic [1:0] top_op;
  logic       main_red;

  logic [DEPTH-1:0][7:0] a_stk;
  logic [CW-1:0]         a_cnt;
  logic [OD-1:0][1:0]    c0_ops;
  logic [1:0]            c0_opc;

  logic                  en1, en2;
  logic [OD-1:0][1:0]    u1_ops_in;
  logic [1:0]            u1_opc_in;
  logic [DEPTH-1:0][7:0] u1_stk;
  logic [CW-1:0]         u1_cnt;
  logic [1:0]            u1_opc;
  logic [7:0]            u1_step;
  logic [1:0]            u1_kind;
  logic [7:0]            u1_right, u1_left, u1_temp;
  logic                  u1_bad;

  logic [OD-1:0][1:0]    d_ops;
  logic [1:0]            d_opc;
  logic [OD-1:0][1:0]    u2_ops_in;
  logic [1:0]            u2_opc_in;
  logic [DEPTH-1:0][7:0] u2_stk;
  logic [CW-1:0]         u2_cnt;
  logic [1:0]            u2_opc;
  logic [7:0]            u2_step;
  logic [1:0]            u2_kind;
  logic [7:0]            u2_right, u2_left, u2_temp;
  logic                  u2_bad;

  // decode and the steps before the first reduction
  always_comb begin
    is_operand = (char_i >= itas_pkg::CHAR_A) && (char_i <= itas_pkg::CHAR_M);
    is_opr     = 1'b1;
    kind       = itas_pkg::OP_ADD;
    unique case (char_i)
      itas_pkg::CHAR_PLUS:  kind = itas_pkg::OP_ADD;
      itas_pkg::CHAR_MINUS: kind = itas_pkg::OP_SUB;
      itas_pkg::CHAR_TIMES: kind = itas_pkg::OP_MUL;
      itas_pkg::CHAR_DIV:   kind = itas_pkg::OP_DIV;
      default:              is_opr = 1'b0;
    endcase

    opc_m1 = opc_r - 2'd1;
    top_op = ops_r[opc_m1[0]];

    // pending * or / after an operand, pending + or - before a new + or -
    if (is_operand) begin
      main_red = (opc_r != 2'd0) && top_op[1];
    end else begin
      main_red = is_opr && !kind[1] && (opc_r != 2'd0) && !top_op[1];
    end

    a_stk = stk_r;
    a_cnt = cnt_r;
    if (is_operand && (cnt_r < CW'(DEPTH))) begin
      a_stk[cnt_r[IW-1:0]] = char_i;
      a_cnt = cnt_r + CW'(1);
    end

    c0_ops = ops_r;
    c0_opc = opc_r;
    if (is_opr && (opc_r < 2'(OD))) begin
      c0_ops[opc_r[0]] = kind;
      c0_opc = opc_r + 2'd1;
    end

    u1_ops_in = main_red ? ops_r : c0_ops;
    u1_opc_in = main_red ? opc_r : c0_opc;
    en1       = main_red || (end_i && (c0_opc != 2'd0));
  end

  itas_reduce #(.DEPTH(DEPTH)) u_red1 (
    .en_i        (en1),
    .stk_i       (a_stk),
    .cnt_i       (a_cnt),
    .ops_i       (u1_ops_in),
    .opc_i       (u1_opc_in),
    .step_i      (step_r),
    .stk_o       (u1_stk),
    .cnt_o       (u1_cnt),
    .opc_o       (u1_opc),
    .step_o      (u1_step),
    .op_kind_o   (u1_kind),
    .right_o     (u1_right),
    .left_o      (u1_left),
    .temp_o      (u1_temp),
    .malformed_o (u1_bad)
  );

  // operator push that follows a main reduction, then end-of-expression drain
  always_comb begin
    d_ops = ops_r;
    d_opc = u1_opc;
    if (is_opr && (u1_opc < 2'(OD))) begin
      d_ops[u1_opc[0]] = kind;
      d_opc = u1_opc + 2'd1;
    end
    u2_ops_in = main_red ? d_ops : c0_ops;
    u2_opc_in = main_red ? d_opc : u1_opc;
    en2       = end_i && en1 && (u2_opc_in != 2'd0);
  end

  itas_reduce #(.DEPTH(DEPTH)) u_red2 (
    .en_i        (en2),
    .stk_i       (u1_stk),
    .cnt_i       (u1_cnt),
    .ops_i       (u2_ops_in),
    .opc_i       (u2_opc_in),
    .step_i      (u1_step),
    .stk_o       (u2_stk),
    .cnt_o       (u2_cnt),
    .opc_o       (u2_opc),
    .step_o      (u2_step),
    .op_kind_o   (u2_kind),
    .right_o     (u2_right),
    .left_o      (u2_left),
    .temp_o      (u2_temp),
    .malformed_o (u2_bad)
  );

  always_comb begin
    emit_o.count                  = {1'b0, en1} + {1'b0, en2};
    emit_o.first.op_kind          = u1_kind;
    emit_o.first.right_operand    = u1_right;
    emit_o.first.left_operand     = u1_left;
    emit_o.first.temp_name        = u1_temp;
    emit_o.first.last_of_run      = !en2;
    emit_o.first.expression_done  = end_i && !en2;
    emit_o.first.malformed        = u1_bad;
    emit_o.second.op_kind         = u2_kind;
    emit_o.second.right_operand   = u2_right;
    emit_o.second.left_operand    = u2_left;
    emit_o.second.temp_name       = u2_temp;
    emit_o.second.last_of_run     = 1'b1;
    emit_o.second.expression_done = end_i;
    emit_o.second.malformed       = u2_bad;

    stk_nxt  = u2_stk;
    ops_nxt  = u2_ops_in;
    cnt_nxt  = u2_cnt;
    opc_nxt  = u2_opc;
    step_nxt = u2_step;
    if (end_i) begin
      cnt_nxt  = '0;
      opc_nxt  = 2'd0;
      step_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      opc_r  <= 2'd0;
      step_r <= 8'd0;
    end else if (adv_i) begin
      cnt_r  <= cnt_nxt;
      opc_r  <= opc_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      stk_r <= stk_nxt;
      ops_r <= ops_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("operand count beyond stack depth");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv_i && end_i |=> (cnt_r == '0) && (opc_r == 2'd0) && (step_r == 8'd0))
    else $error("stacks not cleared after end of expression");

  a_two_steps: assert property (@(posedge clk) disable iff (!rst_n)
    emit_o.count == 2'd2 |-> !emit_o.first.last_of_run && end_i)
    else $error("two steps without end of expression or wrong run marker");

endmodule

@@ src/infix_to_three_address_steps.sv @@
// infix_to_three_address_steps: top level; input register, stack core and a
// two-beat result buffer; uses itas_pkg, itas_in_if, itas_out_if, itas_core
//
//   channel   direction  beat contents
//   in_ch     sink       char_code, end_of_expression
//   out_ch    source     op_kind, right_operand, left_operand, temp_name,
//                        last_of_run, expression_done, malformed
//
// a character is registered in s1, then decoded against the stacks and reduced once
// the result buffer is free; its zero, one or two steps land in the result buffer
// one character per cycle when it makes at most one step and out_ch.ready is high;
// a character that makes two steps holds the input until the result buffer drains
// rst_n is synchronous and active low; it empties both stacks and the buffer
// out_ch.ready low stalls the core while any beat waits; in_ch.ready drops while s1 is held
module infix_to_three_address_steps #(
  parameter int OPERAND_DEPTH = 4
) (
  input logic        clk,
  input logic        rst_n,
  itas_in_if.sink    in_ch,
  itas_out_if.source out_ch
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_end_r;
  logic       s1_adv;

  // result buffer: slot 0 is the front beat
  logic [1:0]     out_cnt_r, out_cnt_nxt;
  itas_pkg::res_t slot0_r,   slot0_nxt;
  itas_pkg::res_t slot1_r,   slot1_nxt;
  logic           out_pop;
  logic           buf_free;

  itas_pkg::emit_t emit;

  assign out_pop  = out_ch.valid && out_ch.ready;
  // core may push only when the buffer will be empty after this cycle
  assign buf_free = (out_cnt_r == 2'd0) || ((out_cnt_r == 2'd1) && out_pop);
  assign s1_adv   = s1_valid_r && buf_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_code;
      s1_end_r  <= in_ch.end_of_expression;
    end
  end

  itas_core #(.DEPTH(OPERAND_DEPTH)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (s1_adv),
    .char_i (s1_char_r),
    .end_i  (s1_end_r),
    .emit_o (emit)
  );

  always_comb begin
    out_cnt_nxt = out_cnt_r;
    slot0_nxt   = slot0_r;
    slot1_nxt   = slot1_r;
    if (s1_adv) begin
      out_cnt_nxt = emit.count;
      slot0_nxt   = emit.first;
      slot1_nxt   = emit.second;
    end else if (out_pop) begin
      out_cnt_nxt = out_cnt_r - 2'd1;
      slot0_nxt   = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cnt_r <= 2'd0;
    end else begin
      out_cnt_r <= out_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_ch.valid           = (out_cnt_r != 2'd0);
  assign out_ch.op_kind         = slot0_r.op_kind;
  assign out_ch.right_operand   = slot0_r.right_operand;
  assign out_ch.left_operand    = slot0_r.left_operand;
  assign out_ch.temp_name       = slot0_r.temp_name;
  assign out_ch.last_of_run     = slot0_r.last_of_run;
  assign out_ch.expression_done = slot0_r.expression_done;
  assign out_ch.malformed       = slot0_r.malformed;

  a_buf_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r != 2'd3)
    else $error("result buffer holds more than two beats");

  a_front_of_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r == 2'd2 |-> !slot0_r.last_of_run && slot1_r.last_of_run)
    else $error("run marker misplaced in buffered pair");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.expression_done |-> out_ch.last_of_run)
    else $error("expression end on a beat that is not last of its run");

endmodule

@@ dv/itas_step_checker.sv @@
// itas_step_checker: watches both channels of the infix-to-steps block, predicts the
// steps of every accepted character and compares them; uses itas_pkg, itas_in_if, itas_out_if
module itas_step_checker
  import itas_pkg::*;
#(
  parameter int OPERAND_DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  itas_in_if   in_ch,
  itas_out_if  out_ch,
  output int   error_count,
  output int   steps_outstanding
);

  localparam int STEPS_PER_CHAR = 2;
  localparam int REPORT_LIMIT   = 10;

  logic [7:0] operands [OPERAND_DEPTH];
  int         operand_cnt;
  logic [1:0] operators [OPERATOR_DEPTH];
  int         operator_cnt;
  logic [7:0] step_cnt;

  res_t expected_steps [$];
  res_t seen_step;
  res_t wanted_step;
  int   errors;

  function automatic logic [7:0] pop_operand(inout logic empty);
    if (operand_cnt == 0) begin
      empty = 1'b1;
      return 8'd0;
    end
    operand_cnt--;
    return operands[operand_cnt];
  endfunction

  function automatic void push_operand(input logic [7:0] v);
    if (operand_cnt < OPERAND_DEPTH) begin
      operands[operand_cnt] = v;
      operand_cnt++;
    end
  endfunction

  // pops the top operator and two operands, pushes the temporary back
  function automatic res_t reduce_top();
    res_t r;
    logic empty;
    empty = 1'b0;
    operator_cnt--;
    r.op_kind         = operators[operator_cnt];
    r.right_operand   = pop_operand(empty);
    r.left_operand    = pop_operand(empty);
    r.temp_name       = TEMP_BASE - step_cnt;
    r.last_of_run     = 1'b0;
    r.expression_done = 1'b0;
    r.malformed       = empty;
    push_operand(r.temp_name);
    step_cnt++;
    return r;
  endfunction

  function automatic void predict_steps(input logic [7:0] c, input logic closes);
    res_t made [$];
    logic [1:0] kind;
    logic is_op;
    is_op = 1'b1;
    kind  = OP_ADD;
    case (c)
      CHAR_PLUS:  kind = OP_ADD;
      CHAR_MINUS: kind = OP_SUB;
      CHAR_TIMES: kind = OP_MUL;
      CHAR_DIV:   kind = OP_DIV;
      default:    is_op = 1'b0;
    endcase
    if (c >= CHAR_A && c <= CHAR_M) begin
      push_operand(c);
      if (operator_cnt > 0 && operators[operator_cnt - 1] >= OP_MUL)
        made = {made, reduce_top()};
    end else if (is_op) begin
      // a new add/sub first folds a pending add/sub
      if (kind < OP_MUL && operator_cnt > 0 && operators[operator_cnt - 1] < OP_MUL)
        made = {made, reduce_top()};
      if (operator_cnt < OPERATOR_DEPTH) begin
        operators[operator_cnt] = kind;
        operator_cnt++;
      end
    end
    if (closes) begin
      while (operator_cnt > 0 && made.size() < STEPS_PER_CHAR)
        made = {made, reduce_top()};
      operand_cnt  = 0;
      operator_cnt = 0;
      step_cnt     = 8'd0;
    end
    if (made.size() > 0) begin
      made[made.size() - 1].last_of_run     = 1'b1;
      made[made.size() - 1].expression_done = closes;
    end
    foreach (made[i]) expected_steps = {expected_steps, made[i]};
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf("op %0d right %02h left %02h temp %02h last %b done %b malformed %b",
                     r.op_kind, r.right_operand, r.left_operand, r.temp_name,
                     r.last_of_run, r.expression_done, r.malformed);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      operand_cnt  = 0;
      operator_cnt = 0;
      step_cnt     = 8'd0;
      expected_steps.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_steps(in_ch.char_code, in_ch.end_of_expression);
      if (out_ch.valid && out_ch.ready) begin
        seen_step.op_kind         = out_ch.op_kind;
        seen_step.right_operand   = out_ch.right_operand;
        seen_step.left_operand    = out_ch.left_operand;
        seen_step.temp_name       = out_ch.temp_name;
        seen_step.last_of_run     = out_ch.last_of_run;
        seen_step.expression_done = out_ch.expression_done;
        seen_step.malformed       = out_ch.malformed;
        if (expected_steps.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("unexpected step beat: %s", describe(seen_step));
          errors++;
        end else begin
          wanted_step = expected_steps.pop_front();
          if (seen_step !== wanted_step) begin
            if (errors < REPORT_LIMIT)
              $display("step mismatch: expected %s, got %s",
                       describe(wanted_step), describe(seen_step));
            errors++;
          end
        end
      end
    end
    error_count       <= errors;
    steps_outstanding <= expected_steps.size();
  end

endmodule

@@ dv/testbench.sv @@
// testbench: drives characters into infix_to_three_address_steps and paces its step
// output; checking lives in itas_step_checker; uses itas_pkg and both channel interfaces
module testbench;
  import itas_pkg::*;

  localparam int OPERAND_DEPTH = 4;
  localparam int ITEM_TARGET   = 1100;  // operand and operator beats, strays not counted
  localparam int CHAIN_LENGTH  = 270;   // long add chain, enough to wrap the temp counter
  localparam int HOLD_CYCLES   = 400;   // one long sink stall to back the block up
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 400000;

  // pacing of the two sides over the run
  typedef enum {SINK_SLOW, SOURCE_SLOW, FREE_RUN} pace_t;

  logic clk = 1'b0;
  logic rst_n;

  itas_in_if  in_ch ();
  itas_out_if out_ch ();

  int    error_count;
  int    steps_outstanding;
  int    significant_sent = 0;
  pace_t pace = SINK_SLOW;

  // 4 time unit period
  always #2 clk = ~clk;

  infix_to_three_address_steps #(
    .OPERAND_DEPTH(OPERAND_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  itas_step_checker #(
    .OPERAND_DEPTH(OPERAND_DEPTH)
  ) step_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .error_count       (error_count),
    .steps_outstanding (steps_outstanding)
  );

  // idle percentages per pacing phase
  function automatic int source_idle(input pace_t p);
    case (p)
      SINK_SLOW:   return 36;
      SOURCE_SLOW: return 75;
      default:     return 0;
    endcase
  endfunction

  function automatic int sink_idle(input pace_t p);
    case (p)
      SINK_SLOW:   return 75;
      SOURCE_SLOW: return 36;
      default:     return 0;
    endcase
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_TIMES || c == CHAR_DIV;
  endfunction

  function automatic logic is_significant(input logic [7:0] c);
    return (c >= CHAR_A && c <= CHAR_M) || is_operator(c);
  endfunction

  function automatic logic [7:0] random_operand();
    return CHAR_A + 8'($urandom_range(CHAR_M - CHAR_A));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_TIMES;
      default: return CHAR_DIV;
    endcase
  endfunction

  // any character the block ignores (spaces, digits, n..z, control codes, high codes)
  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (is_significant(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  // offer one character beat and hold it until the block takes it
  task automatic send_char(input logic [7:0] c, input logic closes);
    if (significant_sent < ITEM_TARGET / 3)
      pace = SINK_SLOW;
    else if (significant_sent < 2 * ITEM_TARGET / 3)
      pace = SOURCE_SLOW;
    else
      pace = FREE_RUN;
    while ($urandom_range(99) < source_idle(pace)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.char_code         <= c;
    in_ch.end_of_expression <= closes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (is_significant(c)) significant_sent++;
  endtask

  task automatic send_text(input string s, input logic closes);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], closes && (i == s.len() - 1));
  endtask

  task automatic maybe_stray();
    if ($urandom_range(9) == 0) send_char(stray_char(), 1'b0);
  endtask

  // well-formed expression with random operands and operators, strays sprinkled in
  task automatic send_expression();
    int  n;
    logic tail;
    n    = $urandom_range(1, 5);
    tail = ($urandom_range(9) == 0);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        maybe_stray();
        send_char(random_operator(), 1'b0);
        maybe_stray();
      end
      send_char(random_operand(), (i == n - 1) && !tail);
    end
    // end flag riding on an ignored character
    if (tail) send_char(stray_char(), 1'b1);
  endtask

  // broken sequence: operands and operators in no particular order
  task automatic send_jumble();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send_char($urandom_range(1) ? random_operand() : random_operator(),
                (i == n - 1) && $urandom_range(1));
  endtask

  // raw noise over the whole character range, end flags at random
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      send_char(8'($urandom_range(255)), $urandom_range(4) == 0);
  endtask

  // a+b+c+... long enough that temporary names run past 0 and wrap
  task automatic send_chain();
    for (int i = 0; i < CHAIN_LENGTH; i++) begin
      send_char(random_operand(), 1'b0);
      send_char(CHAR_PLUS, 1'b0);
    end
    send_char(random_operand(), 1'b1);
  endtask

  // sink side: random stalls, plus one long hold-off once traffic runs free
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (pace == FREE_RUN && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle(pace));
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int  pick;
    logic chain_done;
    chain_done              = 1'b0;
    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.char_code         = 8'd0;
    in_ch.end_of_expression = 1'b0;
    out_ch.ready            = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    send_text("m/a", 1'b1);       // operand extremes, divide folds right after an operand
    send_text("a*+-", 1'b1);      // three pending folds at the end: two emitted, one dropped,
                                  // with an empty operand pop on the way
    send_text("+", 1'b1);         // lone operator: both pops find the stack empty
    send_text("abcde+f", 1'b1);   // operand stack full, extra operands dropped
    send_text("a-b-c", 1'b1);     // left associativity of subtract
    send_char(8'h00, 1'b0);       // ignored character extremes, end with nothing pending
    send_char(8'hFF, 1'b1);
    send_text("b/ ", 1'b1);       // end flag on an ignored character with an operator pending

    // random part
    while (significant_sent < ITEM_TARGET) begin
      if (!chain_done && significant_sent >= ITEM_TARGET / 2) begin
        send_chain();
        chain_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 75)
        send_expression();
      else if (pick < 90)
        send_noise();
      else
        send_jumble();
    end
    in_ch.valid <= 1'b0;

    // let every predicted step come out, then drain for DRAIN_CYCLES to catch stragglers
    while (steps_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
